@@ sv/plc_pkg.sv @@
// Shared types and constants for the piecewise-linear calibration block.
// Used by plc_table, plc_div and piecewise_linear_calibration; no dependencies.
package plc_pkg;

  localparam int TableDepth = 64;
  localparam int IdxW = $clog2(TableDepth);
  localparam int ValW = 24;
  localparam int NumW = 50;
  localparam int SpanW = 26;
  localparam int CountW = 7;

  localparam logic [0:0] OpWrite = 1'b0;
  localparam logic [0:0] OpCorrect = 1'b1;

  localparam logic [0:0] RegPointCount = 1'b0;
  localparam logic [0:0] RegUseCorrection = 1'b1;

  localparam logic signed [ValW-1:0] ValMax = 24'sh7FFFFF;
  localparam logic signed [ValW-1:0] ValMin = -24'sh800000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_CMP,
    ST_MUL,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_SUM,
    ST_OUT,
    ST_PASS
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

@@ sv/piecewise_linear_calibration.sv @@
// Top level of the piecewise-linear calibration block: control sequencer,
// APB register file and result stage. Depends on plc_pkg, plc_table, plc_div.
//
// A write beat (op = 0) stores one set/measured pair in the table memory at
// the accepting edge and never raises busy, so the next beat may follow in
// the very next cycle. A correct beat (op = 1) scans segments from entry 0
// upward, reading one table entry per cycle from the single read port. When
// the sample lands in the segment whose high point is entry k, busy stays high
// through the scan (RD0 and RD1 prime the read, then one compare per entry),
// the multiply, the divider start, the 50-step bit-serial division and its
// done flag, and the sum and saturation. With correction off, or with fewer
// than two points, a sample keeps busy high for one cycle. A sample that
// matches no segment keeps it high until the scan has compared the last
// entry. The result appears on corrected/segment_found/saturated for exactly
// one cycle with result_valid high, in the first cycle with busy low; a new
// beat may be accepted in that same cycle. The receiver cannot stall the
// result, so it must take it.
module piecewise_linear_calibration (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic op,
  input  logic [5:0] entry_index,
  input  logic signed [23:0] set_point,
  input  logic signed [23:0] measured_point,
  input  logic signed [23:0] sample,
  output logic result_valid,
  output logic signed [23:0] corrected,
  output logic segment_found,
  output logic saturated,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  localparam int VW = plc_pkg::ValW;

  plc_pkg::state_t state, state_next;

  // Configuration registers.
  logic [plc_pkg::CountW-1:0] point_count;
  logic use_correction;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      use_correction <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        plc_pkg::RegPointCount: point_count <= pwdata[plc_pkg::CountW-1:0];
        plc_pkg::RegUseCorrection: use_correction <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      plc_pkg::RegPointCount: prdata = {{(32-plc_pkg::CountW){1'b0}}, point_count};
      plc_pkg::RegUseCorrection: prdata = {31'd0, use_correction};
      default: prdata = '0;
    endcase
  end

  // Effective count, clipped to the table depth.
  logic [plc_pkg::CountW-1:0] eff_count;
  assign eff_count = (point_count > plc_pkg::CountW'(plc_pkg::TableDepth))
                     ? plc_pkg::CountW'(plc_pkg::TableDepth) : point_count;

  // Item registers.
  logic signed [VW-1:0] smp;
  logic [plc_pkg::CountW-1:0] idx;     // index of the entry being read
  logic signed [VW-1:0] s_lo;         // previous entry
  logic signed [VW:0] e_lo_w;
  logic signed [VW+1:0] de;
  logic signed [VW:0] dx;
  logic [plc_pkg::SpanW-1:0] span;
  logic signed [plc_pkg::NumW-1:0] num;
  logic signed [VW+2:0] sum;
  logic accept;

  assign accept = start && !busy;

  // Table memory.
  logic tbl_we;
  logic signed [VW-1:0] rd_set, rd_meas;
  logic [plc_pkg::IdxW-1:0] rd_addr;

  assign tbl_we = accept && (op == plc_pkg::OpWrite);
  assign rd_addr = (state == plc_pkg::ST_CMP) ? plc_pkg::IdxW'(idx + 1'b1)
                                              : idx[plc_pkg::IdxW-1:0];

  plc_table u_table (
    .clk(clk),
    .wr_en(tbl_we),
    .wr_addr(entry_index),
    .wr_set(set_point),
    .wr_meas(measured_point),
    .rd_addr(rd_addr),
    .rd_set(rd_set),
    .rd_meas(rd_meas)
  );

  // Divider.
  logic div_start;
  plc_pkg::div_ctl_t div_ctl;
  logic signed [plc_pkg::NumW-1:0] quot;

  plc_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num(num),
    .den(span),
    .ctl(div_ctl),
    .quot(quot)
  );

  // The hit test on the entry just read against the previous one.
  logic hit;
  logic last;
  assign hit = (smp > s_lo) && (smp <= rd_set);
  assign last = (idx + 1'b1) >= eff_count;

  always_comb begin
    state_next = state;
    unique case (state)
      plc_pkg::ST_IDLE:
        if (accept && op == plc_pkg::OpCorrect) begin
          state_next = (use_correction && eff_count >= plc_pkg::CountW'(2))
                       ? plc_pkg::ST_RD0 : plc_pkg::ST_PASS;
        end
      plc_pkg::ST_RD0: state_next = plc_pkg::ST_RD1;
      plc_pkg::ST_RD1: state_next = plc_pkg::ST_CMP;
      plc_pkg::ST_CMP:
        if (hit) state_next = plc_pkg::ST_MUL;
        else if (last) state_next = plc_pkg::ST_PASS;
        else state_next = plc_pkg::ST_CMP;
      plc_pkg::ST_MUL: state_next = plc_pkg::ST_DIVGO;
      plc_pkg::ST_DIVGO: state_next = plc_pkg::ST_DIVWAIT;
      plc_pkg::ST_DIVWAIT: if (div_ctl.done) state_next = plc_pkg::ST_SUM;
      plc_pkg::ST_SUM: state_next = plc_pkg::ST_OUT;
      plc_pkg::ST_OUT: state_next = plc_pkg::ST_IDLE;
      plc_pkg::ST_PASS: state_next = plc_pkg::ST_IDLE;
      default: state_next = plc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != plc_pkg::ST_IDLE);
    div_start = (state == plc_pkg::ST_DIVGO);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= plc_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Datapath. The read at idx issued in one cycle returns data the next;
  // in CMP, rd_set/rd_meas hold entry idx-1+1 (the high point) while the
  // read address has already advanced, so idx is bumped on each miss in CMP.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      unique case (state)
        plc_pkg::ST_IDLE: idx <= '0;
        plc_pkg::ST_RD0: idx <= plc_pkg::CountW'(1);
        plc_pkg::ST_RD1: idx <= plc_pkg::CountW'(1);
        plc_pkg::ST_CMP: if (!hit) idx <= idx + 1'b1;
        default: ;
      endcase
    end
  end

  // In RD1 the data of entry 0 arrives; the read of entry 1 was issued in RD1
  // with idx = 1, so in CMP rd_* is entry idx. Bumping idx while CMP repeats
  // needs the read of idx+1 in the same cycle: the read address runs ahead.
  // On a hit the low point is kept, since the sum still needs its error.
  always_ff @(posedge clk) begin
    if (accept) smp <= sample;
    unique case (state)
      plc_pkg::ST_RD1: begin
        s_lo <= rd_set;
        e_lo_w <= (VW+1)'(rd_set) - (VW+1)'(rd_meas);
      end
      plc_pkg::ST_CMP: begin
        if (hit) begin
          de <= (VW+2)'((VW+1)'(rd_set) - (VW+1)'(rd_meas)) - (VW+2)'(e_lo_w);
          dx <= (VW+1)'(smp) - (VW+1)'(s_lo);
          span <= plc_pkg::SpanW'((VW+1)'(rd_set) - (VW+1)'(s_lo));
        end else begin
          s_lo <= rd_set;
          e_lo_w <= (VW+1)'(rd_set) - (VW+1)'(rd_meas);
        end
      end
      plc_pkg::ST_MUL: num <= plc_pkg::NumW'(de * dx);
      plc_pkg::ST_SUM:
        sum <= (VW+3)'(smp) + (VW+3)'(e_lo_w) + (VW+3)'(quot);
      default: ;
    endcase
  end

  // The scan reads entry idx in CMP; the memory address must run one ahead.
  // RD0 issues entry 0, RD1 issues entry 1, CMP issues idx+1.

  // Result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (state == plc_pkg::ST_OUT || state == plc_pkg::ST_PASS) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == plc_pkg::ST_PASS) begin
      corrected <= smp;
      segment_found <= 1'b0;
      saturated <= 1'b0;
    end else if (state == plc_pkg::ST_OUT) begin
      segment_found <= 1'b1;
      if (sum > (VW+3)'(plc_pkg::ValMax)) begin
        corrected <= plc_pkg::ValMax;
        saturated <= 1'b1;
      end else if (sum < (VW+3)'(plc_pkg::ValMin)) begin
        corrected <= plc_pkg::ValMin;
        saturated <= 1'b1;
      end else begin
        corrected <= sum[VW-1:0];
        saturated <= 1'b0;
      end
    end
  end

  // A result is always presented while the sequencer is back in idle.
  assert property (@(posedge clk) disable iff (rst) result_valid |-> !busy)
    else $error("result while busy");
  assert property (@(posedge clk) disable iff (rst) div_ctl.done |-> state == plc_pkg::ST_DIVWAIT)
    else $error("divider finished outside wait state");
  assert property (@(posedge clk) disable iff (rst)
    (state == plc_pkg::ST_MUL) |-> span != '0)
    else $error("zero span in matched segment");

endmodule

@@ sv/plc_table.sv @@
// Calibration table: one synchronous memory holding set and measured pairs.
// Depends on plc_pkg. One write port, one read port, registered read data.
module plc_table (
  input  logic clk,
  input  logic wr_en,
  input  logic [plc_pkg::IdxW-1:0] wr_addr,
  input  logic signed [plc_pkg::ValW-1:0] wr_set,
  input  logic signed [plc_pkg::ValW-1:0] wr_meas,
  input  logic [plc_pkg::IdxW-1:0] rd_addr,
  output logic signed [plc_pkg::ValW-1:0] rd_set,
  output logic signed [plc_pkg::ValW-1:0] rd_meas
);

  logic [2*plc_pkg::ValW-1:0] mem [plc_pkg::TableDepth];
  logic [2*plc_pkg::ValW-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_set, wr_meas};
    end
    rd_word <= mem[rd_addr];
  end

  assign rd_set = $signed(rd_word[2*plc_pkg::ValW-1:plc_pkg::ValW]);
  assign rd_meas = $signed(rd_word[plc_pkg::ValW-1:0]);

endmodule

@@ sv/plc_div.sv @@
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// Depends on plc_pkg. Divisor is strictly positive when started.
module plc_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [plc_pkg::NumW-1:0] num,
  input  logic [plc_pkg::SpanW-1:0] den,
  output plc_pkg::div_ctl_t ctl,
  output logic signed [plc_pkg::NumW-1:0] quot
);

  localparam int CntW = $clog2(plc_pkg::NumW + 1);

  logic [plc_pkg::NumW-1:0] q;
  logic [plc_pkg::SpanW:0] rem;
  logic [plc_pkg::SpanW-1:0] dv;
  logic neg;
  logic [CntW-1:0] cnt;
  logic running;
  logic done;
  logic [plc_pkg::SpanW:0] trial;
  logic [plc_pkg::SpanW:0] diff;

  assign trial = {rem[plc_pkg::SpanW-1:0], q[plc_pkg::NumW-1]};
  assign diff = trial - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt <= CntW'(plc_pkg::NumW);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[plc_pkg::NumW-1];
      q <= num[plc_pkg::NumW-1] ? -num : num;
      rem <= '0;
      dv <= den;
    end else if (running) begin
      if (!diff[plc_pkg::SpanW]) begin
        rem <= diff;
        q <= {q[plc_pkg::NumW-2:0], 1'b1};
      end else begin
        rem <= trial;
        q <= {q[plc_pkg::NumW-2:0], 1'b0};
      end
    end
  end

  assign quot = neg ? -$signed(q) : $signed(q);
  assign ctl.start = start;
  assign ctl.busy = running;
  assign ctl.done = done;

endmodule
